### design/uws_pkg.sv
// ----------------------------------------------------------------------------
// uws_pkg
// Types, constants and character-class functions of the UTF-8 word splitter.
// ----------------------------------------------------------------------------
package uws_pkg;

    localparam int CP_W        = 21;
    localparam int BYTE_W      = 8;
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // one result item
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            token_start;
        logic            text_end;
    } result_t;

    // one decoded character and the number of bytes that it consumed
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [2:0]      used;
    } decoded_t;

    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] c);
        logic [2:0] len;
        len = 3'd1;
        if (!c[7])
        begin
            len = 3'd1;
        end
        else if (c[7:5] == 3'b110)
        begin
            len = 3'd2;
        end
        else if (c[7:4] == 4'b1110)
        begin
            len = 3'd3;
        end
        else if (c[7:3] == 5'b11110)
        begin
            len = 3'd4;
        end
        return len;
    endfunction

    // decode one character from up to four bytes, avail of them present
    function automatic decoded_t decode_char(input logic [BYTE_W-1:0] b0,
                                             input logic [BYTE_W-1:0] b1,
                                             input logic [BYTE_W-1:0] b2,
                                             input logic [BYTE_W-1:0] b3,
                                             input logic [2:0]        avail);
        decoded_t   d;
        logic [2:0] len;
        len    = lead_length(b0);
        d.cp   = REPLACEMENT_CP;
        d.used = 3'd1;
        if (!b0[7])
        begin
            d.cp = {13'd0, b0};
        end
        else if (len > 3'd1 && avail >= len)
        begin
            d.used = len;
            case (len)
                3'd2:    d.cp = {10'd0, b0[4:0], b1[5:0]};
                3'd3:    d.cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                3'd4:    d.cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                default: d.cp = REPLACEMENT_CP;
            endcase
        end
        return d;
    endfunction

    function automatic logic [CP_W-1:0] to_lower(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] r;
        r = cp;
        if (cp inside {[21'h41 : 21'h5A]})
        begin
            r = cp + 21'd32;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [CP_W-1:0] cp);
        return cp inside {21'h09, 21'h0A, 21'h0D, 21'h20, 21'hA0};
    endfunction

    function automatic logic is_punct(input logic [CP_W-1:0] cp);
        return cp inside {[21'h21 : 21'h2F], [21'h3A : 21'h40], [21'h5B : 21'h60],
                          [21'h7B : 21'h7E], [21'h2000 : 21'h206F],
                          [21'h3000 : 21'h303F], [21'hFF00 : 21'hFFEF]};
    endfunction

    function automatic logic is_cjk(input logic [CP_W-1:0] cp);
        return cp inside {[21'h4E00 : 21'h9FFF], [21'h3400 : 21'h4DBF],
                          [21'h20000 : 21'h2A6DF], [21'h2A700 : 21'h2CEAF],
                          [21'hF900 : 21'hFAFF], [21'h2F800 : 21'h2FA1F]};
    endfunction

endpackage

### design/uws_if.sv
// ----------------------------------------------------------------------------
// uws_if
// Valid/ready channels of the UTF-8 word splitter: text bytes in, characters out.
// ----------------------------------------------------------------------------
interface uws_in_if import uws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface uws_out_if import uws_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            token_start;
    logic            text_end;

    modport source (output valid, output code_point, output token_start,
                    output text_end, input ready);
    modport sink   (input valid, input code_point, input token_start,
                    input text_end, output ready);
endinterface

### design/utf8_basic_word_splitter_top.sv
// ----------------------------------------------------------------------------
// utf8_basic_word_splitter_top
// Splits a UTF-8 byte stream into lowercased codepoints with token-start flags.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the result queue has room. A byte goes
// into an input register, is decoded against the buffered partial character in
// one pass, and its results land in a four-entry result queue that drains one
// item per cycle while the sink is ready. An ordinary byte gives zero or one
// result, so the stream runs at one byte per cycle while the sink keeps up. The
// byte marked last flushes the buffer and gives up to four results including
// the end-of-text item; the next byte waits until the queue is down to its
// final entry.
module utf8_basic_word_splitter_top import uws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    uws_in_if.sink    text,
    uws_out_if.source tokens
);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // partial character state
    logic [BYTE_W-1:0] pending_bytes_reg [3];
    logic [1:0]        pending_count_reg;
    logic [2:0]        char_length_reg;
    logic              inside_word_reg;

    // result queue, entry zero at the head
    result_t           res_reg [MAX_RESULTS];
    logic [RES_CNT_W-1:0] res_count_reg;

    logic              fire;
    logic              take;
    logic [BYTE_W-1:0] buf_b [4];
    logic [2:0]        cnt;
    logic [2:0]        len0;
    logic              complete;
    decoded_t          dec [4];
    result_t           res_next [MAX_RESULTS];
    logic [RES_CNT_W-1:0] n_next;
    logic              word_next;
    logic [2:0]        pos;
    logic              active;
    logic [CP_W-1:0]   lcp;

    assign take       = tokens.valid && tokens.ready;
    assign fire       = in_valid_reg &&
                        (res_count_reg == '0 || (res_count_reg == RES_CNT_W'(1) && take));
    assign text.ready = !in_valid_reg || fire;

    assign tokens.valid       = res_count_reg != '0;
    assign tokens.code_point  = res_reg[0].code_point;
    assign tokens.token_start = res_reg[0].token_start;
    assign tokens.text_end    = res_reg[0].text_end;

    // append the new byte to the buffered ones
    always_comb
    begin
        cnt = {1'b0, pending_count_reg} + 3'd1;
        for (int i = 0; i < 3; i++)
        begin
            buf_b[i] = (pending_count_reg == 2'(i)) ? in_byte_reg : pending_bytes_reg[i];
        end
        buf_b[3] = (pending_count_reg == 2'd3) ? in_byte_reg : '0;
        len0     = (pending_count_reg != 2'd0) ? char_length_reg : lead_length(in_byte_reg);
        complete = cnt >= len0;

        dec[0] = decode_char(buf_b[0], buf_b[1], buf_b[2], buf_b[3], cnt);
        dec[1] = decode_char(buf_b[1], buf_b[2], buf_b[3], 8'h00, cnt - 3'd1);
        dec[2] = decode_char(buf_b[2], buf_b[3], 8'h00, 8'h00, cnt - 3'd2);
        dec[3] = decode_char(buf_b[3], 8'h00, 8'h00, 8'h00, cnt - 3'd3);
    end

    // walk the characters of this byte and classify each one
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_next[i] = '0;
        end
        n_next    = '0;
        word_next = inside_word_reg;
        pos       = 3'd0;
        active    = 1'b0;
        lcp       = '0;
        for (int s = 0; s < 4; s++)
        begin
            active = in_last_reg ? (pos < cnt) : (s == 0 && complete);
            if (active)
            begin
                lcp = to_lower(dec[pos[1:0]].cp);
                if (is_space(lcp))
                begin
                    word_next = 1'b0;
                end
                else if (is_punct(lcp) || is_cjk(lcp))
                begin
                    res_next[n_next[1:0]] = '{code_point: lcp, token_start: 1'b1,
                                              text_end: 1'b0};
                    n_next    = n_next + RES_CNT_W'(1);
                    word_next = 1'b0;
                end
                else
                begin
                    res_next[n_next[1:0]] = '{code_point: lcp, token_start: !word_next,
                                              text_end: 1'b0};
                    n_next    = n_next + RES_CNT_W'(1);
                    word_next = 1'b1;
                end
                pos = pos + dec[pos[1:0]].used;
            end
        end
        // end-of-text item, dropped if the queue is already full
        if (in_last_reg && n_next < RES_CNT_W'(MAX_RESULTS))
        begin
            res_next[n_next[1:0]] = '{code_point: '0, token_start: 1'b0, text_end: 1'b1};
            n_next = n_next + RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            pending_count_reg <= '0;
            char_length_reg   <= '0;
            inside_word_reg   <= 1'b0;
            res_count_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pending_bytes_reg[i] <= '0;
            end
        end
        else
        begin
            if (text.ready)
            begin
                in_valid_reg <= text.valid;
            end
            if (fire)
            begin
                res_count_reg <= n_next;
                if (in_last_reg)
                begin
                    pending_count_reg <= '0;
                    char_length_reg   <= '0;
                    inside_word_reg   <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        pending_bytes_reg[i] <= '0;
                    end
                end
                else if (complete)
                begin
                    pending_count_reg <= '0;
                    char_length_reg   <= '0;
                    inside_word_reg   <= word_next;
                end
                else
                begin
                    // hold the partial character
                    pending_count_reg <= cnt[1:0];
                    char_length_reg   <= len0;
                    for (int i = 0; i < 3; i++)
                    begin
                        pending_bytes_reg[i] <= buf_b[i];
                    end
                end
            end
            else if (take)
            begin
                res_count_reg <= res_count_reg - RES_CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.text_byte;
            in_last_reg <= text.last_byte;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
        else if (take)
        begin
            // advance the queue
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_reg[i] <= res_reg[i + 1];
            end
        end
    end

    a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        pending_count_reg != 2'd0 |->
            (char_length_reg > {1'b0, pending_count_reg} && char_length_reg <= 3'd4))
        else $error("partial character longer than its lead byte allows");

    a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result queue overfilled");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=>
            (pending_count_reg == 2'd0 && char_length_reg == 3'd0 && !inside_word_reg))
        else $error("state not cleared after end of text");

    a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.text_end |->
            (tokens.code_point == '0 && !tokens.token_start))
        else $error("end-of-text item carries a character");

endmodule
